FILE: src/plml_pkg.sv
// Shared constants, codes and helpers for the pool-backed linked list manager.
`timescale 1ns / 1ps
package plml_pkg;

  // Pool size and the widths that follow from it.
  localparam int NODES  = 64;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = IDX_W + 1;

  // Link values beyond the pool are markers.
  localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(NODES);
  localparam logic [LINK_W-1:0] HEAD_MARK = LINK_W'(NODES + 1);

  // Command codes.
  localparam logic [2:0] CMD_RESET  = 3'd0;
  localparam logic [2:0] CMD_FRONT  = 3'd1;
  localparam logic [2:0] CMD_BACK   = 3'd2;
  localparam logic [2:0] CMD_INSERT = 3'd3;
  localparam logic [2:0] CMD_ERASE  = 3'd4;
  localparam logic [2:0] CMD_RANGE  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXHAUST  = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;
  localparam logic [1:0] ST_NO_END   = 2'd3;

  // Limits the configured pool size to one through the full pool.
  function automatic logic [LINK_W-1:0] clamp_pool(input logic [6:0] v);
    logic [LINK_W-1:0] r;
    if (v == 7'd0) begin
      r = LINK_W'(1);
    end else if (LINK_W'(v) > END_MARK || v > 7'(NODES)) begin
      r = END_MARK;
    end else begin
      r = LINK_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: src/plml_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read.
`timescale 1ns / 1ps
module plml_ram
  import plml_pkg::*;
#(
  parameter int AW = IDX_W,
  parameter int DW = LINK_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pool_linked_list_manager.sv
// Top level: doubly linked list over a node pool, with a free stack, in two link RAMs.
// Range erase walks the list node by node to the range end, then frees the nodes one by one;
// bad positions and an empty pool go straight to the result. One item at a time; busy stays
// high through the result strobe cycle, so a new item is taken only after the last result.
// Reset (rst, synchronous) rebuilds the free chain over all 64 entries; busy is high
// meanwhile. Results appear on done for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module pool_linked_list_manager
  import plml_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command,
  input  logic [6:0] position,
  input  logic [6:0] range_end,
  output logic       done,
  output logic [6:0] result_node,
  output logic [1:0] status,
  output logic [6:0] live_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_W1   = 4'd3;
  localparam logic [3:0] S_INS_W2   = 4'd4;
  localparam logic [3:0] S_ERS_RD   = 4'd5;
  localparam logic [3:0] S_ERS_W1   = 4'd6;
  localparam logic [3:0] S_ERS_W2   = 4'd7;
  localparam logic [3:0] S_WALK_RD  = 4'd8;
  localparam logic [3:0] S_WALK_CHK = 4'd9;
  localparam logic [3:0] S_RNG_PV   = 4'd10;
  localparam logic [3:0] S_RNG_LINK = 4'd11;
  localparam logic [3:0] S_FREE_RD  = 4'd12;
  localparam logic [3:0] S_FREE_WB  = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  logic [3:0]        state;
  logic [6:0]        pool_entries;
  logic [NODES-1:0]  live;
  logic [LINK_W-1:0] first_node, last_node, free_top, used_count;
  logic [LINK_W-1:0] clr_cnt, clr_n;
  logic              report;
  logic              front;
  logic [LINK_W-1:0] pos, rend, nx, pv, p, steps, res;
  logic [IDX_W-1:0]  nnode;
  logic [1:0]        stat;

  // RAM ports.
  logic              nl_we, pl_we;
  logic [IDX_W-1:0]  nl_waddr, pl_waddr, nl_raddr, pl_raddr;
  logic [LINK_W-1:0] nl_wdata, pl_wdata, nl_rdata, pl_rdata;

  // Decoded values for the item at the input.
  logic              pos_live, p_live;
  logic [LINK_W-1:0] ins_nx, pv_c, fill;

  plml_ram #(.AW(IDX_W), .DW(LINK_W)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(nl_raddr), .rdata(nl_rdata)
  );

  plml_ram #(.AW(IDX_W), .DW(LINK_W)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_FIN);
  assign result_node = res;
  assign status      = stat;
  assign live_count  = used_count;
  assign cfg_ready   = 1'b1;

  // Liveness of the requested position, and whether the cursor node lies inside the pool.
  assign pos_live = (position < END_MARK) && live[position[IDX_W-1:0]];
  assign p_live   = (p < END_MARK);

  // Successor for an insertion, and the predecessor once the prev link is read.
  always_comb begin
    if (command == CMD_FRONT) begin
      ins_nx = first_node;
    end else begin
      ins_nx = (command == CMD_BACK || position == END_MARK) ? END_MARK : position;
    end
    if (front) begin
      pv_c = HEAD_MARK;
    end else begin
      pv_c = (nx < END_MARK) ? pl_rdata : last_node;
    end
    fill = ((clr_cnt + LINK_W'(1)) < clr_n) ? clr_cnt + LINK_W'(1) : END_MARK;
  end

  // RAM address and write selection per state.
  always_comb begin
    nl_raddr = (state == S_INS_RD) ? nnode : p[IDX_W-1:0];
    case (state)
      S_INS_RD: pl_raddr = nx[IDX_W-1:0];
      S_RNG_PV: pl_raddr = pos[IDX_W-1:0];
      default:  pl_raddr = p[IDX_W-1:0];
    endcase
    nl_we    = 1'b0;
    nl_waddr = p[IDX_W-1:0];
    nl_wdata = free_top;
    pl_we    = 1'b0;
    pl_waddr = nnode;
    pl_wdata = pv_c;
    case (state)
      S_CLR: begin
        nl_we    = 1'b1;
        nl_waddr = clr_cnt[IDX_W-1:0];
        nl_wdata = fill;
      end
      S_INS_W1: begin
        nl_we    = 1'b1;
        nl_waddr = nnode;
        nl_wdata = nx;
        pl_we    = 1'b1;
      end
      S_INS_W2: begin
        nl_we    = (pv < END_MARK);
        nl_waddr = pv[IDX_W-1:0];
        nl_wdata = LINK_W'(nnode);
        pl_we    = (nx < END_MARK);
        pl_waddr = nx[IDX_W-1:0];
        pl_wdata = LINK_W'(nnode);
      end
      S_ERS_W1: begin
        nl_we    = (pl_rdata < END_MARK);
        nl_waddr = pl_rdata[IDX_W-1:0];
        nl_wdata = nl_rdata;
        pl_we    = (nl_rdata < END_MARK);
        pl_waddr = nl_rdata[IDX_W-1:0];
        pl_wdata = pl_rdata;
      end
      S_ERS_W2, S_FREE_WB: begin
        nl_we = 1'b1;
      end
      S_RNG_LINK: begin
        nl_we    = (pl_rdata < END_MARK);
        nl_waddr = pl_rdata[IDX_W-1:0];
        nl_wdata = rend;
        pl_we    = (rend < END_MARK);
        pl_waddr = rend[IDX_W-1:0];
        pl_wdata = pl_rdata;
      end
      default: begin
      end
    endcase
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      pool_entries <= 7'(NODES);
      clr_cnt      <= '0;
      clr_n        <= END_MARK;
      report       <= 1'b0;
      live         <= '0;
      first_node   <= END_MARK;
      last_node    <= HEAD_MARK;
      free_top     <= '0;
      used_count   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pool_entries <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            pos  <= position;
            rend <= range_end;
            res  <= END_MARK;
            stat <= ST_OK;
            case (command)
              CMD_RESET: begin
                clr_cnt <= '0;
                clr_n   <= clamp_pool(pool_entries);
                report  <= 1'b1;
                state   <= S_CLR;
              end
              CMD_FRONT, CMD_BACK, CMD_INSERT: begin
                front <= (command == CMD_FRONT);
                nx    <= ins_nx;
                nnode <= free_top[IDX_W-1:0];
                if (command == CMD_INSERT && position != END_MARK && !pos_live) begin
                  stat  <= ST_NOT_LIVE;
                  state <= S_FIN;
                end else if (free_top >= END_MARK) begin
                  stat  <= ST_EXHAUST;
                  state <= S_FIN;
                end else begin
                  state <= S_INS_RD;
                end
              end
              CMD_ERASE: begin
                p <= position;
                if (!pos_live) begin
                  stat  <= ST_NOT_LIVE;
                  state <= S_FIN;
                end else begin
                  state <= S_ERS_RD;
                end
              end
              CMD_RANGE: begin
                p     <= position;
                steps <= '0;
                if (position != END_MARK && !pos_live) begin
                  stat  <= ST_NOT_LIVE;
                  state <= S_FIN;
                end else if (position == range_end) begin
                  res   <= range_end;
                  state <= S_FIN;
                end else begin
                  state <= S_WALK_RD;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        // Rebuild the free chain one entry a cycle.
        S_CLR: begin
          clr_cnt <= clr_cnt + LINK_W'(1);
          if (clr_cnt == END_MARK - LINK_W'(1)) begin
            live       <= '0;
            first_node <= END_MARK;
            last_node  <= HEAD_MARK;
            free_top   <= '0;
            used_count <= '0;
            state      <= report ? S_FIN : S_IDLE;
          end
        end
        S_INS_RD: state <= S_INS_W1;
        // Pop the free stack and link the new node to its neighbors.
        S_INS_W1: begin
          free_top <= nl_rdata;
          pv       <= pv_c;
          state    <= S_INS_W2;
        end
        S_INS_W2: begin
          if (nx >= END_MARK) begin
            last_node <= LINK_W'(nnode);
          end
          if (pv >= END_MARK) begin
            first_node <= LINK_W'(nnode);
          end
          live[nnode] <= 1'b1;
          used_count  <= used_count + LINK_W'(1);
          res         <= LINK_W'(nnode);
          state       <= S_FIN;
        end
        S_ERS_RD: state <= S_ERS_W1;
        // Unlink one node, then push it on the free stack.
        S_ERS_W1: begin
          if (nl_rdata >= END_MARK) begin
            last_node <= pl_rdata;
          end
          if (pl_rdata >= END_MARK) begin
            first_node <= nl_rdata;
          end
          res   <= nl_rdata;
          state <= S_ERS_W2;
        end
        S_ERS_W2: begin
          free_top             <= p;
          live[p[IDX_W-1:0]]   <= 1'b0;
          if (used_count != '0) begin
            used_count <= used_count - LINK_W'(1);
          end
          state <= S_FIN;
        end
        // Walk from the range start looking for the range end.
        S_WALK_RD: begin
          if (p_live && steps <= END_MARK) begin
            state <= S_WALK_CHK;
          end else begin
            stat  <= ST_NO_END;
            state <= S_FIN;
          end
        end
        S_WALK_CHK: begin
          steps <= steps + LINK_W'(1);
          if (nl_rdata == rend) begin
            p     <= pos;
            state <= S_RNG_PV;
          end else begin
            p     <= nl_rdata;
            state <= S_WALK_RD;
          end
        end
        S_RNG_PV: state <= S_RNG_LINK;
        // Bridge the predecessor of the range to its end.
        S_RNG_LINK: begin
          if (pl_rdata >= END_MARK) begin
            first_node <= rend;
          end
          if (rend >= END_MARK) begin
            last_node <= pl_rdata;
          end
          res   <= rend;
          state <= S_FREE_RD;
        end
        // Free the range nodes one by one.
        S_FREE_RD: begin
          state <= (p_live && p != rend) ? S_FREE_WB : S_FIN;
        end
        S_FREE_WB: begin
          free_top           <= p;
          live[p[IDX_W-1:0]] <= 1'b0;
          if (used_count != '0) begin
            used_count <= used_count - LINK_W'(1);
          end
          p     <= nl_rdata;
          state <= S_FREE_RD;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/pool_linked_list_checker.sv
// Checker for the linked list manager: predicts each result and compares it field by field.
`timescale 1ns / 1ps
module pool_linked_list_checker
  import plml_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] command,
  input  logic [6:0] position,
  input  logic [6:0] range_end,
  input  logic       done,
  input  logic [6:0] result_node,
  input  logic [1:0] status,
  input  logic [6:0] live_count,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [6:0] node;
    logic [1:0] st;
    logic [6:0] count;
  } list_answer_t;

  // Shadow copy of the list, the free stack and the pool setting.
  logic [6:0] nxt [NODES];
  logic [6:0] prv [NODES];
  logic       live [NODES];
  logic [6:0] head, tail, free_head, used, pool_cfg;

  // Small ring of answers still to come; one item is in flight at most.
  list_answer_t answers_due [4];
  int due_rd, due_wr;

  // Rebuilds the free chain over the configured number of entries.
  task automatic rebuild_pool();
    int n;
    n = int'(pool_cfg);
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    for (int i = 0; i < NODES; i++) begin
      nxt[i] = (i + 1 < n) ? 7'(i + 1) : END_MARK;
      live[i] = 1'b0;
    end
    head = END_MARK;
    tail = HEAD_MARK;
    free_head = 7'd0;
    used = 7'd0;
  endtask

  function automatic bit node_live(logic [6:0] p);
    return p < NODES && live[p];
  endfunction

  // Returns a freed node to the top of the free stack.
  task automatic free_node(logic [6:0] n);
    nxt[n] = free_head;
    free_head = n;
    live[n] = 1'b0;
    if (used > 7'd0) used = used - 7'd1;
  endtask

  // Applies one command to the shadow list and works out its answer.
  task automatic apply_list_command(input logic [2:0] cmd, input logic [6:0] pos,
                                    input logic [6:0] rend, output list_answer_t a);
    logic [6:0] res, nx, pv, n, walk, p;
    logic [1:0] st;
    int steps;
    bit found;
    res = END_MARK;
    st = ST_OK;
    case (cmd)
      CMD_RESET: begin
        rebuild_pool();
      end
      CMD_FRONT, CMD_BACK, CMD_INSERT: begin
        if (cmd == CMD_FRONT) nx = head;
        else if (cmd == CMD_BACK || pos == END_MARK) nx = END_MARK;
        else if (node_live(pos)) nx = pos;
        else st = ST_NOT_LIVE;
        if (st == ST_OK) begin
          if (free_head >= NODES) begin
            st = ST_EXHAUST;
          end else begin
            n = free_head;
            free_head = nxt[n];
            live[n] = 1'b1;
            used = used + 7'd1;
            if (cmd == CMD_FRONT) pv = HEAD_MARK;
            else pv = (nx < NODES) ? prv[nx] : tail;
            nxt[n] = nx;
            prv[n] = pv;
            if (nx < NODES) prv[nx] = n; else tail = n;
            if (pv < NODES) nxt[pv] = n; else head = n;
            res = n;
          end
        end
      end
      CMD_ERASE: begin
        if (!node_live(pos)) begin
          st = ST_NOT_LIVE;
        end else begin
          nx = nxt[pos];
          pv = prv[pos];
          if (nx < NODES) prv[nx] = pv; else tail = pv;
          if (pv < NODES) nxt[pv] = nx; else head = nx;
          free_node(pos);
          res = nx;
        end
      end
      CMD_RANGE: begin
        if (pos != END_MARK && !node_live(pos)) begin
          st = ST_NOT_LIVE;
        end else if (pos == rend) begin
          res = rend;
        end else begin
          walk = pos;
          steps = 0;
          found = 0;
          while (walk < NODES && steps <= NODES && !found) begin
            walk = nxt[walk];
            steps++;
            if (walk == rend) found = 1;
          end
          if (!found) begin
            st = ST_NO_END;
          end else begin
            pv = prv[pos];
            if (pv < NODES) nxt[pv] = rend; else head = rend;
            if (rend < NODES) prv[rend] = pv; else tail = pv;
            p = pos;
            while (p < NODES && p != rend) begin
              nx = nxt[p];
              free_node(p);
              p = nx;
            end
            res = rend;
          end
        end
      end
      default: ;
    endcase
    a.node = res;
    a.st = st;
    a.count = used;
  endtask

  assign pending = due_wr - due_rd;

  // Watch the three channels on every rising edge.
  always @(posedge clk) begin
    list_answer_t want, got;
    if (rst) begin
      due_rd = 0;
      due_wr = 0;
      pool_cfg = 7'd64;
      for (int i = 0; i < NODES; i++) prv[i] = 7'd0;
      rebuild_pool();
    end else begin
      if (cfg_valid && cfg_ready) pool_cfg = cfg_data;
      if (done) begin
        got = '{result_node, status, live_count};
        if (due_wr == due_rd) begin
          $error("result with nothing expected: node %0d status %0d count %0d",
                 result_node, status, live_count);
          errors++;
        end else begin
          want = answers_due[due_rd % 4];
          due_rd++;
          if (got.node !== want.node) begin
            $error("result_node: expected %0d, got %0d", want.node, got.node);
            errors++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            errors++;
          end
          if (got.count !== want.count) begin
            $error("live_count: expected %0d, got %0d", want.count, got.count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        apply_list_command(command, position, range_end, want);
        answers_due[due_wr % 4] = want;
        due_wr++;
      end
    end
  end

endmodule

FILE: tb/sv/pool_linked_list_manager_tb.sv
// Testbench top for the linked list manager: drives commands and pool settings, gives the verdict.
`timescale 1ns / 1ps
module pool_linked_list_manager_tb;
  import plml_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] command = CMD_RESET;
  logic [6:0] position = 7'd0;
  logic [6:0] range_end = 7'd0;
  logic cfg_valid = 1'b0;
  logic [6:0] cfg_data = 7'd0;
  logic busy, done, cfg_ready;
  logic [6:0] result_node, live_count;
  logic [1:0] status;
  int errors, pending;
  int idle_pct = 0;
  int pool_now = 64;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  pool_linked_list_manager dut (
    .clk, .rst, .start, .busy, .command, .position, .range_end, .done,
    .result_node, .status, .live_count, .cfg_valid, .cfg_ready, .cfg_data
  );

  pool_linked_list_checker chk (
    .clk, .rst, .start, .busy, .command, .position, .range_end, .done,
    .result_node, .status, .live_count, .cfg_valid, .cfg_ready, .cfg_data,
    .errors, .pending
  );

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issues one command item; start stays high between back-to-back items.
  task automatic send_item(input logic [2:0] cmd, input logic [6:0] pos,
                           input logic [6:0] rend);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    position <= pos;
    range_end <= rend;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  // Waits for all answers, then writes the pool size and rebuilds the pool.
  task automatic set_pool(input logic [6:0] entries);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= entries;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    pool_now = (entries == 0) ? 1 : (entries > 64 ? 64 : entries);
    send_item(CMD_RESET, 7'd0, 7'd0);
  endtask

  // Picks a node index, usually inside the active pool.
  function automatic logic [6:0] pick_node();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return END_MARK;
    if (r < 15) return 7'($urandom_range(0, 64));
    return 7'($urandom_range(0, pool_now - 1));
  endfunction

  task automatic random_item();
    int r;
    logic [6:0] p;
    r = $urandom_range(0, 99);
    p = pick_node();
    if (r < 18) send_item(CMD_FRONT, p, pick_node());
    else if (r < 36) send_item(CMD_BACK, p, pick_node());
    else if (r < 52) send_item(CMD_INSERT, p, pick_node());
    else if (r < 76) send_item(CMD_ERASE, p, pick_node());
    else if (r < 96) send_item(CMD_RANGE, p, pick_node());
    else send_item(CMD_RESET, p, pick_node());
  endtask

  initial begin
    logic [6:0] pools [9] = '{7'd64, 7'd8, 7'd1, 7'd5, 7'd127, 7'd0, 7'd16, 7'd3, 7'd12};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: each command and the error answers.
    send_item(CMD_FRONT, 7'd0, 7'd0);
    send_item(CMD_BACK, 7'd64, 7'd64);
    send_item(CMD_INSERT, END_MARK, 7'd0);
    send_item(CMD_INSERT, 7'd0, 7'd0);
    send_item(CMD_INSERT, 7'd50, 7'd0);
    send_item(CMD_ERASE, 7'd63, 7'd0);
    send_item(CMD_ERASE, END_MARK, 7'd0);
    send_item(CMD_RANGE, 7'd1, 7'd1);
    send_item(CMD_RANGE, END_MARK, 7'd3);
    send_item(CMD_RANGE, 7'd1, 7'd40);
    send_item(CMD_RANGE, 7'd50, 7'd1);
    send_item(CMD_ERASE, 7'd1, 7'd0);
    send_item(CMD_RANGE, 7'd3, END_MARK);
    send_item(CMD_FRONT, 7'd127, 7'd127);
    send_item(CMD_RANGE, END_MARK, END_MARK);
    send_item(CMD_ERASE, 7'd3, 7'd0);
    set_pool(7'd1);
    send_item(CMD_FRONT, 7'd0, 7'd0);
    send_item(CMD_BACK, 7'd0, 7'd0);
    send_item(CMD_INSERT, 7'd0, 7'd0);
    send_item(CMD_INSERT, 7'd9, 7'd0);
    send_item(CMD_RANGE, 7'd0, END_MARK);

    // Random part over several pool sizes and three idling modes.
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 32 : (ph < 6 ? 78 : 0);
      set_pool(pools[ph]);
      repeat (60) random_item();
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
